/* hdl/value_pair_histogram_macros.svh */
`ifndef VALUE_PAIR_HISTOGRAM_MACROS_SVH
`define VALUE_PAIR_HISTOGRAM_MACROS_SVH

// check that a condition is followed in the same cycle by another
`define VPH_ASSERT_IMPLY(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("value_pair_histogram: implication check failed");

// check that a condition never holds
`define VPH_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("value_pair_histogram: forbidden condition seen");

`endif

/* hdl/vph_pkg.sv */
package vph_pkg;

  localparam int unsigned AXIS_BITS_DEF  = 10;
  localparam int unsigned WORD_SHIFT_DEF = 6;
  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned INDEX_BITS = 10;
  localparam int unsigned OUT_BITS   = 32;

  typedef enum logic [1:0] {
    KIND_COUNT,
    KIND_READ,
    KIND_READ_CLEAR,
    KIND_CLEAR_MAX
  } kind_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

endpackage

/* hdl/vph_ram.sv */
module vph_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/value_pair_histogram.sv */
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_tvalid / in_tready | tuser: kind; tdata: first, second, row, column
// out_    | out | out_tvalid/out_tready | tdata: bin_count, max_count
// cfg_    | in  | cfg_tvalid/cfg_tready | tdata: pair_mode
//
// One item a cycle unless the output stalls: accept issues the bin read; stage one
// modifies and writes back, forwarding the written count to a following same-bin item.
// After reset the bin store is swept to zero, one bin a cycle, all 2^(2*AXIS_BITS)
// bins (1048576 by default); in_tready stays low until the sweep ends.
// A full output register not taken holds the item in the modify stage and stalls input.
module value_pair_histogram #(
  parameter int unsigned AXIS_BITS  = vph_pkg::AXIS_BITS_DEF,
  parameter int unsigned WORD_SHIFT = vph_pkg::WORD_SHIFT_DEF,
  parameter int unsigned COUNT_BITS = vph_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // kind[1:0]
  input  logic [55:0] in_tdata,   // first_value[15:0], second_value[31:16],
                                  // bin_row[41:32], bin_column[51:42], zero[55:52]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // bin_count[31:0], max_count[63:32]
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata   // pair_mode[0], zero[7:1]
);

  `include "value_pair_histogram_macros.svh"

  localparam int unsigned AddrBits = 2 * AXIS_BITS;
  localparam int unsigned Depth    = 1 << AddrBits;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  vph_pkg::state_t st_r, st_nxt;
  logic            clearing;
  logic [AddrBits-1:0] clr_addr_r, clr_addr_nxt;

  logic pair_mode_r, pair_mode_nxt;

  logic                  s1_valid_r, s1_valid_nxt;
  vph_pkg::kind_t        s1_kind_r, s1_kind_nxt;
  logic [AddrBits-1:0]   s1_addr_r, s1_addr_nxt;
  logic                  s1_fwd_r, s1_fwd_nxt;
  logic [COUNT_BITS-1:0] s1_fwd_data_r, s1_fwd_data_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [vph_pkg::OUT_BITS-1:0] out_bin_r, out_bin_nxt;
  logic [vph_pkg::OUT_BITS-1:0] out_max_r, out_max_nxt;
  logic [COUNT_BITS-1:0] peak_r, peak_nxt;

  vph_pkg::kind_t in_kind;
  logic [vph_pkg::VALUE_BITS-1:0] first_value, second_value;
  logic [vph_pkg::INDEX_BITS-1:0] bin_row, bin_column;
  logic [15:0] row_src, col_src;
  logic [AddrBits-1:0] acc_addr;
  logic in_acc;
  logic s1_adv;
  logic s1_wr;

  logic [COUNT_BITS-1:0] cur_count, wr_count, bin_res;
  logic [63:0]           bin_wide, peak_wide;

  logic                  ram_wr_en, ram_rd_en;
  logic [AddrBits-1:0]   ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data, ram_rd_data;

  // state machine
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      vph_pkg::ST_CLEAR: begin
        if (clr_addr_r == '1) begin
          st_nxt = vph_pkg::ST_RUN;
        end
      end
      vph_pkg::ST_RUN: st_nxt = vph_pkg::ST_RUN;
      default:         st_nxt = vph_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    unique case (st_r)
      vph_pkg::ST_CLEAR: clearing = 1'b1;
      vph_pkg::ST_RUN:   clearing = 1'b0;
      default:           clearing = 1'b1;
    endcase
  end

  assign clr_addr_nxt = clearing ? clr_addr_r + 1'b1 : clr_addr_r;

  // configuration
  assign cfg_tready    = 1'b1;
  assign pair_mode_nxt = (cfg_tvalid && cfg_tready) ? cfg_tdata[0] : pair_mode_r;

  // input decode
  assign in_kind      = vph_pkg::kind_t'(in_tuser);
  assign first_value  = in_tdata[15:0];
  assign second_value = in_tdata[31:16];
  assign bin_row      = in_tdata[41:32];
  assign bin_column   = in_tdata[51:42];

  always_comb begin
    if (in_kind == vph_pkg::KIND_COUNT) begin
      if (pair_mode_r) begin
        row_src = {8'h00, first_value[7:0]};
        col_src = {8'h00, second_value[7:0]};
      end else begin
        row_src = first_value >> WORD_SHIFT;
        col_src = second_value >> WORD_SHIFT;
      end
    end else begin
      row_src = {6'd0, bin_row};
      col_src = {6'd0, bin_column};
    end
  end

  assign acc_addr = {row_src[AXIS_BITS-1:0], col_src[AXIS_BITS-1:0]};

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clearing && (!s1_valid_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;
  assign s1_wr     = s1_adv && (s1_kind_r == vph_pkg::KIND_COUNT ||
                                s1_kind_r == vph_pkg::KIND_READ_CLEAR);

  // stage one capture, forward a bin written this cycle
  always_comb begin
    s1_valid_nxt    = s1_valid_r;
    s1_kind_nxt     = s1_kind_r;
    s1_addr_nxt     = s1_addr_r;
    s1_fwd_nxt      = s1_fwd_r;
    s1_fwd_data_nxt = s1_fwd_data_r;
    if (in_acc) begin
      s1_valid_nxt    = 1'b1;
      s1_kind_nxt     = in_kind;
      s1_addr_nxt     = acc_addr;
      s1_fwd_nxt      = s1_wr && (acc_addr == s1_addr_r);
      s1_fwd_data_nxt = wr_count;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      s1_fwd_nxt   = 1'b0;
    end
  end

  // modify
  assign cur_count = s1_fwd_r ? s1_fwd_data_r : ram_rd_data;

  always_comb begin
    wr_count = '0;
    bin_res  = '0;
    peak_nxt = peak_r;
    unique case (s1_kind_r)
      vph_pkg::KIND_COUNT: begin
        wr_count = (cur_count != CountMax) ? cur_count + 1'b1 : cur_count;
        bin_res  = wr_count;
        if (s1_adv && wr_count > peak_r) begin
          peak_nxt = wr_count;
        end
      end
      vph_pkg::KIND_READ: begin
        bin_res = cur_count;
      end
      vph_pkg::KIND_READ_CLEAR: begin
        bin_res = cur_count;
      end
      vph_pkg::KIND_CLEAR_MAX: begin
        if (s1_adv) begin
          peak_nxt = '0;
        end
      end
      default: bin_res = '0;
    endcase
  end

  assign bin_wide  = 64'(bin_res);
  assign peak_wide = 64'(peak_nxt);

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bin_nxt   = out_bin_r;
    out_max_nxt   = out_max_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_bin_nxt   = bin_wide[vph_pkg::OUT_BITS-1:0];
      out_max_nxt   = peak_wide[vph_pkg::OUT_BITS-1:0];
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_max_r, out_bin_r};

  // bin store
  assign ram_rd_en   = in_acc;
  assign ram_wr_en   = clearing || s1_wr;
  assign ram_wr_addr = clearing ? clr_addr_r : s1_addr_r;
  assign ram_wr_data = clearing ? '0 : wr_count;

  vph_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (Depth)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (acc_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= vph_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      pair_mode_r <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_fwd_r    <= 1'b0;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
    end else begin
      st_r        <= st_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pair_mode_r <= pair_mode_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_fwd_r    <= s1_fwd_nxt;
      out_valid_r <= out_valid_nxt;
      peak_r      <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r     <= s1_kind_nxt;
    s1_addr_r     <= s1_addr_nxt;
    s1_fwd_data_r <= s1_fwd_data_nxt;
    out_bin_r     <= out_bin_nxt;
    out_max_r     <= out_max_nxt;
  end

  `VPH_ASSERT_IMPLY(a_sweep_empty, clearing, !s1_valid_r && !out_valid_r)
  `VPH_ASSERT_IMPLY(a_fwd_live, s1_fwd_r, s1_valid_r)
  `VPH_ASSERT_NEVER(a_stall_no_read, s1_valid_r && !s1_adv && ram_rd_en)
  `VPH_ASSERT_NEVER(a_write_clash, clearing && s1_wr)

endmodule
